@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk, except while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ues_pkg.sv @@
// ---------------------------------------------------------------------------
// ues_pkg
// Types, codes and constants shared by the enumeration sequencer modules.
// ---------------------------------------------------------------------------
package ues_pkg;

  localparam int unsigned CONFIG_BUFFER_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CFG_SKIP_DELAYS = 2'd0;
  localparam logic [1:0] CFG_ADDR_SETTLE = 2'd1;
  localparam logic [1:0] CFG_CONF_SETTLE = 2'd2;

  localparam logic [15:0] ADDR_SETTLE_RESET = 16'd50;
  localparam logic [15:0] CONF_SETTLE_RESET = 16'd10;

  localparam logic [3:0] PID_ACK = 4'd2;
  localparam logic [3:0] PID_DAT1 = 4'd11;

  localparam logic [7:0] IFACE_TYPE = 8'd4;
  localparam logic [7:0] CLASS_HID = 8'd3;
  localparam logic [7:0] CLASS_HUB = 8'd9;

  localparam logic [7:0] OFS_RESTART = 8'd0;
  localparam logic [7:0] OFS_TOTAL_LO = 8'd2;
  localparam logic [7:0] OFS_TOTAL_HI = 8'd3;
  localparam logic [7:0] OFS_CONF_VAL = 8'd5;

  localparam logic [7:0] RT_OUT = 8'h00;
  localparam logic [7:0] RT_IN = 8'h80;
  localparam logic [7:0] BREQ_SET_ADDR = 8'd5;
  localparam logic [7:0] BREQ_GET_DESC = 8'd6;
  localparam logic [7:0] BREQ_SET_CONF = 8'd9;
  localparam logic [15:0] VAL_DEV_DESC = 16'h0100;
  localparam logic [15:0] VAL_CONF_DESC = 16'h0200;
  localparam logic [15:0] DEV_DESC_LEN = 16'd18;
  localparam logic [15:0] HDR_LEN = 16'd9;

  typedef enum logic [2:0] {
    PH_SET_ADDR = 3'd0,
    PH_GET_DEV  = 3'd1,
    PH_GET_HDR  = 3'd2,
    PH_SET_CFG  = 3'd3,
    PH_GET_FULL = 3'd4,
    PH_ENUM     = 3'd5,
    PH_STALL    = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    DRV_NONE    = 2'd0,
    DRV_HID     = 2'd1,
    DRV_HUB     = 2'd2,
    DRV_UNKNOWN = 2'd3
  } drv_kind_t;

  typedef enum logic [1:0] {
    ST_WAIT   = 2'd0,
    ST_STEP   = 2'd1,
    ST_STALL  = 2'd2,
    ST_HANDED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_POLL = 1'b0,
    KIND_BYTE = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now;
    logic        ep_idle;
    logic [3:0]  resp_pid;
    logic [7:0]  byte_offset;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic        req_issue;
    logic [7:0]  req_type;
    logic [7:0]  request;
    logic [15:0] req_value;
    logic [15:0] req_length;
    logic        to_config_buffer;
    logic [6:0]  assigned_address;
    logic [1:0]  driver_kind;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] now;
    logic        ep_idle;
    logic        pid_ack;
    logic        pid_dat1;
    logic        ofs_restart;
    logic        ofs_total_lo;
    logic        ofs_total_hi;
    logic        ofs_conf_val;
    logic [7:0]  byte_offset;
    logic [7:0]  byte_value;
  } q_entry_t;

  typedef struct packed {
    logic        skip_delays;
    logic [15:0] address_settle_ticks;
    logic [15:0] config_settle_ticks;
  } cfg_t;

endpackage

@@ rtl/ues_front.sv @@
// ---------------------------------------------------------------------------
// ues_front
// Accepts input transfers and classifies each item for the execution side.
// ---------------------------------------------------------------------------
module ues_front import ues_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output q_entry_t push_data,
  input  logic     q_ready
);

  logic     valid_r, valid_nxt;
  q_entry_t entry_r, entry_nxt;
  logic     take;

  assign in_stall  = valid_r && !q_ready;
  assign take      = in_valid && !in_stall;
  assign push      = valid_r && q_ready;
  assign push_data = entry_r;

  always_comb begin
    valid_nxt = take ? 1'b1 : (push ? 1'b0 : valid_r);
    entry_nxt.kind         = in_data.mode ? KIND_BYTE : KIND_POLL;
    entry_nxt.now          = in_data.now;
    entry_nxt.ep_idle      = in_data.ep_idle;
    entry_nxt.pid_ack      = (in_data.resp_pid == PID_ACK);
    entry_nxt.pid_dat1     = (in_data.resp_pid == PID_DAT1);
    entry_nxt.ofs_restart  = (in_data.byte_offset == OFS_RESTART);
    entry_nxt.ofs_total_lo = (in_data.byte_offset == OFS_TOTAL_LO);
    entry_nxt.ofs_total_hi = (in_data.byte_offset == OFS_TOTAL_HI);
    entry_nxt.ofs_conf_val = (in_data.byte_offset == OFS_CONF_VAL);
    entry_nxt.byte_offset  = in_data.byte_offset;
    entry_nxt.byte_value   = in_data.byte_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

@@ rtl/ues_queue.sv @@
// ---------------------------------------------------------------------------
// ues_queue
// Short queue between the classifying front and the executing back.
// ---------------------------------------------------------------------------
module ues_queue import ues_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     q_ready,
  output logic     q_valid,
  output q_entry_t q_head,
  input  logic     pop
);

  `include "assert_macros.svh"

  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign q_ready = (count_r != FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_CLK(a_no_overflow, push |-> (count_r != FULL_CNT), "queue written while full")
  `ASSERT_CLK(a_no_underflow, pop |-> (count_r != '0), "queue read while empty")
  `ASSERT_CLK(a_count_bound, count_r <= FULL_CNT, "queue count beyond depth")

endmodule

@@ rtl/ues_back.sv @@
// ---------------------------------------------------------------------------
// ues_back
// Executes queued items: descriptor walk on bytes, request sequence on polls.
// ---------------------------------------------------------------------------
module ues_back import ues_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "assert_macros.svh"

  phase_t      phase_r, phase_nxt;
  logic [31:0] wake_r, wake_nxt;
  logic [6:0]  next_addr_r, next_addr_nxt;
  logic [6:0]  cur_addr_r, cur_addr_nxt;
  logic [7:0]  conf_val_r, conf_val_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] hdr_pos_r, hdr_pos_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [7:0]  if_class_r, if_class_nxt;
  logic        if_found_r, if_found_nxt;
  drv_kind_t   drv_r, drv_nxt;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic [15:0] pos_eff;
  logic        found_eff;
  logic [16:0] pos_p1;
  logic [16:0] pos_p5;
  logic [16:0] ofs17;
  logic [15:0] pos_sum;
  logic [31:0] wake_eff;
  drv_kind_t   pick;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pos_eff   = q_head.ofs_restart ? '0 : hdr_pos_r;
    found_eff = q_head.ofs_restart ? 1'b0 : if_found_r;
    pos_p1    = {1'b0, pos_eff} + 17'd1;
    pos_p5    = {1'b0, pos_eff} + 17'd5;
    ofs17     = {9'b0, q_head.byte_offset};
    pos_sum   = pos_eff + {8'b0, hdr_len_r};
    wake_eff  = cfg.skip_delays ? q_head.now : wake_r;

    if (!if_found_r || (hdr_pos_r >= total_len_r)) begin
      pick = DRV_UNKNOWN;
    end else if (if_class_r == CLASS_HID) begin
      pick = DRV_HID;
    end else if (if_class_r == CLASS_HUB) begin
      pick = DRV_HUB;
    end else begin
      pick = DRV_UNKNOWN;
    end

    phase_nxt     = phase_r;
    wake_nxt      = wake_r;
    next_addr_nxt = next_addr_r;
    cur_addr_nxt  = cur_addr_r;
    conf_val_nxt  = conf_val_r;
    total_len_nxt = total_len_r;
    hdr_pos_nxt   = hdr_pos_r;
    hdr_len_nxt   = hdr_len_r;
    if_class_nxt  = if_class_r;
    if_found_nxt  = if_found_r;
    drv_nxt       = drv_r;
    out_nxt       = '0;
    out_nxt.status = ST_WAIT;

    if (pop) begin
      if (q_head.kind == KIND_BYTE) begin
        if (q_head.ofs_total_lo) begin
          total_len_nxt[7:0] = q_head.byte_value;
        end
        if (q_head.ofs_total_hi) begin
          total_len_nxt[15:8] = q_head.byte_value;
        end
        if (q_head.ofs_conf_val) begin
          conf_val_nxt = q_head.byte_value;
        end
        hdr_pos_nxt  = pos_eff;
        if_found_nxt = found_eff;
        if_class_nxt = q_head.ofs_restart ? '0 : if_class_r;
        if (ofs17 == {1'b0, pos_eff}) begin
          hdr_len_nxt = q_head.byte_value;
        end else if ((ofs17 == pos_p1) && !found_eff) begin
          if (q_head.byte_value == IFACE_TYPE) begin
            if_found_nxt = 1'b1;
          end else if (hdr_len_r != '0) begin
            hdr_pos_nxt = pos_sum;
            if (pos_sum == {8'b0, q_head.byte_offset}) begin
              hdr_len_nxt = q_head.byte_value;
            end
          end
        end else if (found_eff && (ofs17 == pos_p5)) begin
          if_class_nxt = q_head.byte_value;
        end
      end else if (q_head.ep_idle) begin
        wake_nxt = wake_eff;
        if (wake_eff <= q_head.now) begin
          out_nxt.status = ST_STEP;
          unique case (phase_r)
            PH_SET_ADDR: begin
              out_nxt.req_issue = 1'b1;
              out_nxt.req_type  = RT_OUT;
              out_nxt.request   = BREQ_SET_ADDR;
              out_nxt.req_value = {9'b0, next_addr_r};
              wake_nxt  = q_head.now + {16'b0, cfg.address_settle_ticks};
              phase_nxt = PH_GET_DEV;
            end
            PH_GET_DEV: begin
              if (!q_head.pid_dat1) begin
                phase_nxt = PH_STALL;
              end else begin
                cur_addr_nxt       = next_addr_r;
                next_addr_nxt      = next_addr_r + 7'd1;
                out_nxt.req_issue  = 1'b1;
                out_nxt.req_type   = RT_IN;
                out_nxt.request    = BREQ_GET_DESC;
                out_nxt.req_value  = VAL_DEV_DESC;
                out_nxt.req_length = DEV_DESC_LEN;
                phase_nxt = PH_GET_HDR;
              end
            end
            PH_GET_HDR: begin
              if (!q_head.pid_ack) begin
                phase_nxt = PH_STALL;
              end else begin
                out_nxt.req_issue        = 1'b1;
                out_nxt.req_type         = RT_IN;
                out_nxt.request          = BREQ_GET_DESC;
                out_nxt.req_value        = VAL_CONF_DESC;
                out_nxt.req_length       = HDR_LEN;
                out_nxt.to_config_buffer = 1'b1;
                phase_nxt = PH_SET_CFG;
              end
            end
            PH_SET_CFG: begin
              if (!q_head.pid_ack) begin
                phase_nxt = PH_STALL;
              end else begin
                out_nxt.req_issue = 1'b1;
                out_nxt.req_type  = RT_OUT;
                out_nxt.request   = BREQ_SET_CONF;
                out_nxt.req_value = {8'b0, conf_val_r};
                wake_nxt  = q_head.now + {16'b0, cfg.config_settle_ticks};
                phase_nxt = PH_GET_FULL;
              end
            end
            PH_GET_FULL: begin
              if (!q_head.pid_dat1 || (total_len_r > 16'(CONFIG_BUFFER_BYTES))) begin
                phase_nxt = PH_STALL;
              end else begin
                out_nxt.req_issue        = 1'b1;
                out_nxt.req_type         = RT_IN;
                out_nxt.request          = BREQ_GET_DESC;
                out_nxt.req_value        = VAL_CONF_DESC;
                out_nxt.req_length       = total_len_r;
                out_nxt.to_config_buffer = 1'b1;
                phase_nxt = PH_ENUM;
              end
            end
            PH_ENUM: begin
              if (!q_head.pid_ack) begin
                phase_nxt = PH_STALL;
              end else begin
                drv_nxt   = pick;
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: begin
              phase_nxt = PH_DONE;
            end
            default: begin
              phase_nxt = PH_STALL;
            end
          endcase
          if (phase_nxt == PH_STALL) begin
            out_nxt.status = ST_STALL;
          end else if (phase_nxt == PH_DONE) begin
            out_nxt.status = ST_HANDED;
          end
        end
      end
    end

    out_nxt.assigned_address = cur_addr_nxt;
    out_nxt.driver_kind      = drv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SET_ADDR;
      wake_r      <= '0;
      next_addr_r <= 7'd1;
      cur_addr_r  <= '0;
      conf_val_r  <= '0;
      total_len_r <= '0;
      hdr_pos_r   <= '0;
      hdr_len_r   <= '0;
      if_class_r  <= '0;
      if_found_r  <= 1'b0;
      drv_r       <= DRV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wake_r      <= wake_nxt;
      next_addr_r <= next_addr_nxt;
      cur_addr_r  <= cur_addr_nxt;
      conf_val_r  <= conf_val_nxt;
      total_len_r <= total_len_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      hdr_len_r   <= hdr_len_nxt;
      if_class_r  <= if_class_nxt;
      if_found_r  <= if_found_nxt;
      drv_r       <= drv_nxt;
      out_valid_r <= pop ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  `ASSERT_CLK(a_drv_when_done, (drv_r != DRV_NONE) |-> (phase_r == PH_DONE), "early driver choice")
  `ASSERT_CLK(a_stall_sticks, (phase_r == PH_STALL) |=> (phase_r == PH_STALL), "stall phase left")
  `ASSERT_CLK(a_no_restart, (phase_r != PH_SET_ADDR) |=> (phase_r != PH_SET_ADDR), "restarted")

endmodule

@@ rtl/usb_enumeration_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// usb_enumeration_sequencer_core
// Each result passes the front register, the item queue and the output register.
// Throughput: one item per cycle while the receiver does not stall.
// Reset (synchronous, rst_n low) restores the sequence, the descriptor walk
// and the configuration registers to their defaults; no clearing pass.
// Top level: front classifier, item queue and execution back end.
// ---------------------------------------------------------------------------
module usb_enumeration_sequencer_core import ues_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     push;
  q_entry_t push_data;
  logic     q_ready;
  logic     q_valid;
  q_entry_t q_head;
  logic     pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIP_DELAYS: cfg_nxt.skip_delays          = cfg_wdata[0];
        CFG_ADDR_SETTLE: cfg_nxt.address_settle_ticks = cfg_wdata;
        CFG_CONF_SETTLE: cfg_nxt.config_settle_ticks  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_delays          <= 1'b0;
      cfg_r.address_settle_ticks <= ADDR_SETTLE_RESET;
      cfg_r.config_settle_ticks  <= CONF_SETTLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ues_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  ues_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop)
  );

  ues_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/usb_enumeration_sequencer_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// usb_enumeration_sequencer_core_test
// Drives poll and configuration byte transfers into the enumeration
// sequencer and compares every result with an in-bench prediction of the
// request sequence, the descriptor walk and the driver choice. Both sides
// idle and stall at random, and the receiver holds off once for long enough
// to back the block up.
// ---------------------------------------------------------------------------
module usb_enumeration_sequencer_core_test;
  import ues_pkg::*;

  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  usb_enumeration_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Sequencer state as the testbench expects it to be.
  logic        skip_delays = 1'b0;
  logic [15:0] addr_settle = ADDR_SETTLE_RESET;
  logic [15:0] conf_settle = CONF_SETTLE_RESET;
  phase_t      seq_phase = PH_SET_ADDR;
  logic [31:0] wake_time = '0;
  logic [6:0]  next_addr = 7'd1;
  logic [6:0]  cur_addr = '0;
  logic [7:0]  conf_val = '0;
  logic [15:0] total_len = '0;
  logic [15:0] hdr_pos = '0;
  logic [7:0]  hdr_len = '0;
  logic [7:0]  if_class = '0;
  logic        if_found = 1'b0;
  drv_kind_t   drv = DRV_NONE;

  out_item_t   awaited_reports [$];
  out_item_t   head_report;
  int          fail_count = 0;
  int          transfers_in = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          no_idle = 1'b0;
  bit          oversize_total = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void walk_byte(input logic [7:0] ofs, input logic [7:0] val);
    int unsigned pos;
    if (ofs == OFS_TOTAL_LO) total_len[7:0] = val;
    if (ofs == OFS_TOTAL_HI) total_len[15:8] = val;
    if (ofs == OFS_CONF_VAL) conf_val = val;
    if (ofs == OFS_RESTART) begin
      hdr_pos = '0;
      if_found = 1'b0;
      if_class = '0;
    end
    pos = 32'(hdr_pos);
    if (32'(ofs) == pos) begin
      hdr_len = val;
    end else if (32'(ofs) == pos + 1 && !if_found) begin
      if (val == IFACE_TYPE) begin
        if_found = 1'b1;
      end else if (hdr_len != '0) begin
        hdr_pos = hdr_pos + {8'd0, hdr_len};
        if (hdr_pos == {8'd0, ofs}) hdr_len = val;
      end
    end else if (if_found && 32'(ofs) == pos + 5) begin
      if_class = val;
    end
  endfunction

  function automatic out_item_t enumerate_step(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.mode == KIND_BYTE) begin
      walk_byte(it.byte_offset, it.byte_value);
    end else if (it.ep_idle) begin
      if (skip_delays) wake_time = it.now;
      if (wake_time <= it.now) begin
        r.status = ST_STEP;
        case (seq_phase)
          PH_SET_ADDR: begin
            r.req_issue = 1'b1;
            r.req_type = RT_OUT;
            r.request = BREQ_SET_ADDR;
            r.req_value = {9'd0, next_addr};
            wake_time = it.now + {16'd0, addr_settle};
            seq_phase = PH_GET_DEV;
          end
          PH_GET_DEV: begin
            if (it.resp_pid != PID_DAT1) begin
              seq_phase = PH_STALL;
            end else begin
              cur_addr = next_addr;
              next_addr = next_addr + 7'd1;
              r.req_issue = 1'b1;
              r.req_type = RT_IN;
              r.request = BREQ_GET_DESC;
              r.req_value = VAL_DEV_DESC;
              r.req_length = DEV_DESC_LEN;
              seq_phase = PH_GET_HDR;
            end
          end
          PH_GET_HDR: begin
            if (it.resp_pid != PID_ACK) begin
              seq_phase = PH_STALL;
            end else begin
              r.req_issue = 1'b1;
              r.req_type = RT_IN;
              r.request = BREQ_GET_DESC;
              r.req_value = VAL_CONF_DESC;
              r.req_length = HDR_LEN;
              r.to_config_buffer = 1'b1;
              seq_phase = PH_SET_CFG;
            end
          end
          PH_SET_CFG: begin
            if (it.resp_pid != PID_ACK) begin
              seq_phase = PH_STALL;
            end else begin
              r.req_issue = 1'b1;
              r.req_type = RT_OUT;
              r.request = BREQ_SET_CONF;
              r.req_value = {8'd0, conf_val};
              wake_time = it.now + {16'd0, conf_settle};
              seq_phase = PH_GET_FULL;
            end
          end
          PH_GET_FULL: begin
            if (it.resp_pid != PID_DAT1 || total_len > 16'(CONFIG_BUFFER_BYTES)) begin
              seq_phase = PH_STALL;
            end else begin
              r.req_issue = 1'b1;
              r.req_type = RT_IN;
              r.request = BREQ_GET_DESC;
              r.req_value = VAL_CONF_DESC;
              r.req_length = total_len;
              r.to_config_buffer = 1'b1;
              seq_phase = PH_ENUM;
            end
          end
          PH_ENUM: begin
            if (it.resp_pid != PID_ACK) begin
              seq_phase = PH_STALL;
            end else begin
              if (!if_found || hdr_pos >= total_len) drv = DRV_UNKNOWN;
              else if (if_class == CLASS_HID) drv = DRV_HID;
              else if (if_class == CLASS_HUB) drv = DRV_HUB;
              else drv = DRV_UNKNOWN;
              seq_phase = PH_DONE;
            end
          end
          PH_DONE: ;
          default: seq_phase = PH_STALL;
        endcase
        if (seq_phase == PH_STALL) r.status = ST_STALL;
        else if (seq_phase == PH_DONE) r.status = ST_HANDED;
      end
    end
    r.assigned_address = cur_addr;
    r.driver_kind = drv;
    return r;
  endfunction

  function automatic in_item_t poll_item(input logic [31:0] tick, input logic idle,
                                         input logic [3:0] pid);
    in_item_t it;
    it.mode = KIND_POLL;
    it.now = tick;
    it.ep_idle = idle;
    it.resp_pid = pid;
    it.byte_offset = 8'($urandom);
    it.byte_value = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t byte_item(input logic [7:0] ofs, input logic [7:0] val);
    in_item_t it;
    it = poll_item($urandom, 1'($urandom), 4'($urandom));
    it.mode = KIND_BYTE;
    it.byte_offset = ofs;
    it.byte_value = val;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = poll_item($urandom, 1'($urandom), 4'($urandom));
    it.mode = 1'($urandom);
    return it;
  endfunction

  // A poll that cannot get past the gate: busy endpoint, or still settling.
  function automatic in_item_t gated_poll();
    if (skip_delays || wake_time == '0 || $urandom_range(1) == 0)
      return poll_item($urandom, 1'b0, 4'($urandom));
    return poll_item($urandom_range(wake_time - 1, 0), 1'b1, 4'($urandom));
  endfunction

  task automatic send_item(input in_item_t item);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_reports.push_back(enumerate_step(item));
    transfers_in++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SKIP_DELAYS: skip_delays = val[0];
      CFG_ADDR_SETTLE: addr_settle = val;
      CFG_CONF_SETTLE: conf_settle = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One configuration descriptor set with random content, sent from offset
  // zero upwards, now and then broken, truncated or mixed with other transfers.
  task automatic send_descriptor_set();
    logic [7:0]  set_bytes [$];
    int unsigned order [$];
    int unsigned len;
    int unsigned total;
    int unsigned k;
    logic [7:0]  cls;
    logic [7:0]  kind;
    set_bytes = {8'd9, 8'd2, 8'd0, 8'd0, 8'd1, 8'($urandom), 8'd0, 8'h80, 8'd50};
    repeat ($urandom_range(3)) begin
      len = $urandom_range(12, 2);
      case ($urandom_range(3))
        0: kind = 8'd5;
        1: kind = 8'd11;
        2: kind = 8'h21;
        default: kind = 8'h24;
      endcase
      set_bytes.push_back(8'(len));
      set_bytes.push_back(kind);
      repeat (len - 2) set_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(9) == 0) begin
      set_bytes.push_back(8'd0);
      set_bytes.push_back(8'h24);
    end
    case ($urandom_range(2))
      0: cls = CLASS_HID;
      1: cls = CLASS_HUB;
      default: cls = 8'($urandom);
    endcase
    set_bytes = {set_bytes, 8'd9, IFACE_TYPE, 8'd0, 8'd0, 8'd1, cls, 8'd0, 8'd0, 8'd0};
    if ($urandom_range(1) == 1) set_bytes = {set_bytes, 8'd7, 8'd5, 8'h81, 8'd3, 8'd8, 8'd0, 8'd10};
    total = set_bytes.size();
    case ($urandom_range(9))
      0: total = $urandom_range(total - 1, 0);
      1: total = $urandom_range(16'hFFFF);
      default: ;
    endcase
    set_bytes[2] = total[7:0];
    set_bytes[3] = total[15:8];
    for (k = 0; k < set_bytes.size(); k++) order.push_back(k);
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(order.size() - 2);
      order[k] = k + 1;
      order[k + 1] = k;
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(order.size() - 1)) void'(order.pop_back());
    end
    foreach (order[i]) begin
      if ($urandom_range(99) < 10) send_item(gated_poll());
      else if ($urandom_range(99) < 3) send_item(byte_item(8'($urandom), 8'($urandom)));
      send_item(byte_item(8'(order[i]), set_bytes[order[i]]));
    end
  endtask

  task automatic test_gate_and_address();
    send_item(poll_item(32'hFFFF_FFFF, 1'b0, 4'hF));
    send_item(byte_item(8'hFF, 8'hFF));
    send_item(poll_item(32'd1000, 1'b1, PID_ACK));
    send_item(poll_item(32'd1049, 1'b1, PID_DAT1));
    send_item(poll_item(32'd1050, 1'b1, PID_DAT1));
  endtask

  task automatic test_header_fetch();
    logic [15:0] total;
    logic [7:0]  cfg_header [9];
    oversize_total = ($urandom_range(9) < 2);
    total = oversize_total ? 16'hFFFF : 16'(CONFIG_BUFFER_BYTES);
    cfg_header = '{8'd9, 8'd2, total[7:0], total[15:8], 8'd1, 8'hFF, 8'd0, 8'h80, 8'd50};
    send_item(poll_item(32'd1051, 1'b1, PID_ACK));
    foreach (cfg_header[i]) send_item(byte_item(8'(i), cfg_header[i]));
    wait_idle();
    // The settle time wraps past the top of the timer.
    write_register(CFG_CONF_SETTLE, 16'hFFFF);
    send_item(poll_item(32'hFFFF_FF00, 1'b1, PID_ACK));
    send_item(poll_item(32'h0000_1000, 1'b1, PID_DAT1));
    send_item(poll_item(32'h0000_FEFE, 1'b1, PID_DAT1));
    send_item(poll_item(32'h0000_FEFF, 1'b1, PID_DAT1));
  endtask

  task automatic test_descriptor_walk();
    while (transfers_in < 450) send_descriptor_set();
    no_idle = 1'b1;
    while (transfers_in < 650) send_descriptor_set();
    no_idle = 1'b0;
    while (transfers_in < 850) send_descriptor_set();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) send_descriptor_set();
  endtask

  task automatic test_driver_pick();
    logic [3:0] pid;
    send_descriptor_set();
    pid = PID_ACK;
    if ($urandom_range(9) < 2) begin
      do pid = 4'($urandom); while (pid == PID_ACK);
    end
    send_item(poll_item($urandom_range(32'hFFFF_FFFF, 32'h0000_FEFF), 1'b1, pid));
    repeat (5) send_item(poll_item($urandom_range(32'hFFFF_FFFF, 32'h0000_FEFF), 1'b1,
                                   4'($urandom)));
  endtask

  task automatic test_after_enumeration();
    wait_idle();
    write_register(CFG_SKIP_DELAYS, 16'd1);
    write_register(CFG_ADDR_SETTLE, 16'd0);
    write_register(CFG_CONF_SETTLE, 16'd0);
    repeat (40) send_item(random_item());
    wait_idle();
    write_register(CFG_SKIP_DELAYS, 16'd0);
    write_register(CFG_ADDR_SETTLE, 16'hFFFF);
    repeat (40) send_item(random_item());
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) report_mismatch(what, {16'd0, want}, {16'd0, got});
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'd0, 32'd1);
      end else begin
        head_report = awaited_reports.pop_front();
        compare_field("req_issue", 16'(head_report.req_issue), 16'(out_data.req_issue));
        compare_field("req_type", 16'(head_report.req_type), 16'(out_data.req_type));
        compare_field("request", 16'(head_report.request), 16'(out_data.request));
        compare_field("req_value", head_report.req_value, out_data.req_value);
        compare_field("req_length", head_report.req_length, out_data.req_length);
        compare_field("to_config_buffer", 16'(head_report.to_config_buffer),
                      16'(out_data.to_config_buffer));
        compare_field("assigned_address", 16'(head_report.assigned_address),
                      16'(out_data.assigned_address));
        compare_field("driver_kind", 16'(head_report.driver_kind),
                      16'(out_data.driver_kind));
        compare_field("status", 16'(head_report.status), 16'(out_data.status));
      end
    end
  end

  // The receiver stalls at random, apart from one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 35);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SKIP_DELAYS;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_gate_and_address();
    test_header_fetch();
    test_descriptor_walk();
    test_backpressure();
    test_driver_pick();
    test_after_enumeration();
    wait_idle();
    repeat (4) @(negedge clk);
    if (awaited_reports.size() != 0)
      report_mismatch("results never delivered", 32'd0, 32'(awaited_reports.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ues_pkg.sv
rtl/ues_front.sv
rtl/ues_queue.sv
rtl/ues_back.sv
rtl/usb_enumeration_sequencer_core.sv
tb/usb_enumeration_sequencer_core_test.sv
